// ----- sv/kd_tree_knn_search_defines.svh -----
// Assertion macros for the kd-tree neighbor search block.
// Used by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef KD_TREE_KNN_SEARCH_DEFINES_SVH
`define KD_TREE_KNN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KDK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KDK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kdk_pkg.sv -----
// Shared types and constants of the kd-tree neighbor search block.
// No dependencies; used by the interfaces, the distance unit and the top level.
package kdk_pkg;

    localparam int DIMS       = 16;
    localparam int MAX_NODES  = 1024;
    localparam int MAX_POINTS = 512;
    localparam int HEAP_DEPTH = 1024;
    localparam int MAX_K      = 16;

    localparam int DIM_W  = 4;
    localparam int NODE_W = 10;
    localparam int PIDX_W = 9;
    localparam int PT_AW  = PIDX_W + DIM_W;
    localparam int HEAP_W = 10;
    localparam int DIST_W = 40;
    localparam int K_W    = 5;
    localparam int RANK_W = 4;
    localparam int LEAF_W = 16;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] CMD_NODE    = 2'd0;
    localparam logic [1:0] CMD_POINT   = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_K      = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LEAVES = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_NORM   = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [9:0]        slot;
        logic [3:0]        axis;
        logic signed [15:0] value;
        logic              leaf_flag;
        logic [9:0]        left_child;
        logic [9:0]        right_child;
        logic              last_coord;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [PIDX_W-1:0] point_index;
        logic [DIST_W-1:0] distance;
        logic [K_W-1:0]    found_count;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic               leaf;
        logic [DIM_W-1:0]   axis;
        logic signed [15:0] bound;
        logic [NODE_W-1:0]  lc;
        logic [NODE_W-1:0]  rc;
    } t_node;

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic [NODE_W-1:0] idx;
    } t_hent;

endpackage

// ----- sv/kdk_in_if.sv -----
// Input channel of the kd-tree neighbor search block: valid, ready and one item.
// Depends on kdk_pkg.
interface kdk_in_if;
    logic              valid;
    logic              ready;
    kdk_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/kdk_out_if.sv -----
// Result channel of the kd-tree neighbor search block: valid, ready and one item.
// Depends on kdk_pkg.
interface kdk_out_if;
    logic               valid;
    logic               ready;
    kdk_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/kd_tree_knn_search.sv -----
// Top level of the kd-tree best-bin-first neighbor search block.
// Depends on kdk_pkg, kdk_in_if, kdk_out_if, kdk_term_unit and the defines header.
//
// Usage: node loads, point coordinate loads and query coordinates enter on i_req,
// one item per cycle while the block is idle. A query item with last_coord set
// starts a search; i_req.ready then stays low until the last neighbor is taken.
// Results leave on o_rsp, one item per neighbor in ascending distance order,
// with last set on the final one. A search that finds nothing returns no items.
// A search runs a sequencer over one shared distance unit and the node, point and
// heap memories: a descent level steps S_DESC, S_NODE, S_BT_W and S_BT_D, a heap
// sift-up level S_PU_CHK and S_PU_CMP, a sift-down level S_SD_L, S_SD_LW, S_SD_RW
// (with a right child) and S_SD_CMP, and a leaf S_C_RD, S_C_MAG, S_C_W and S_C_ACC
// per dimension. Results leave at one per cycle while o_rsp.ready is high; a
// stalled receiver holds the current result and the block waits.
// Reset clears the query vector, the point count and the control state and
// loads the registers with k_neighbors 1, max_leaves 1 and norm_mode 0. The
// node and point memories are not cleared. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data by the user only while idle; the block does not check.
`include "kd_tree_knn_search_defines.svh"

module kd_tree_knn_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    kdk_in_if.sink                     i_req,
    kdk_out_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [kdk_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [kdk_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_OUTER  = 5'd1;
    localparam logic [4:0] S_DESC   = 5'd2;
    localparam logic [4:0] S_NODE   = 5'd3;
    localparam logic [4:0] S_BT_W   = 5'd4;
    localparam logic [4:0] S_BT_D   = 5'd5;
    localparam logic [4:0] S_PU_CHK = 5'd6;
    localparam logic [4:0] S_PU_CMP = 5'd7;
    localparam logic [4:0] S_POP0   = 5'd8;
    localparam logic [4:0] S_POP1   = 5'd9;
    localparam logic [4:0] S_POP2   = 5'd10;
    localparam logic [4:0] S_SD_L   = 5'd11;
    localparam logic [4:0] S_SD_LW  = 5'd12;
    localparam logic [4:0] S_SD_RW  = 5'd13;
    localparam logic [4:0] S_SD_CMP = 5'd14;
    localparam logic [4:0] S_POPCHK = 5'd15;
    localparam logic [4:0] S_C_RD   = 5'd16;
    localparam logic [4:0] S_C_MAG  = 5'd17;
    localparam logic [4:0] S_C_W    = 5'd18;
    localparam logic [4:0] S_C_ACC  = 5'd19;
    localparam logic [4:0] S_INS    = 5'd20;
    localparam logic [4:0] S_OUT    = 5'd21;

    logic [4:0] r_state;

    logic [kdk_pkg::K_W-1:0]    r_cfg_k;
    logic [kdk_pkg::LEAF_W-1:0] r_cfg_ml;
    logic                       r_cfg_norm;

    logic signed [15:0] r_query [kdk_pkg::DIMS];
    logic [kdk_pkg::NODE_W-1:0] r_pts_loaded;

    kdk_pkg::t_node node_mem [kdk_pkg::MAX_NODES];
    kdk_pkg::t_node r_node_rd;
    logic signed [15:0] pt_mem [kdk_pkg::MAX_POINTS * kdk_pkg::DIMS];
    logic signed [15:0] r_pt_rd;
    kdk_pkg::t_hent heap_mem [kdk_pkg::HEAP_DEPTH];
    kdk_pkg::t_hent r_hrd;

    logic [kdk_pkg::K_W-1:0]    r_kk;
    logic [kdk_pkg::LEAF_W-1:0] r_emax;
    logic [kdk_pkg::LEAF_W-1:0] r_e;
    logic [kdk_pkg::NODE_W:0]   r_steps;
    logic [kdk_pkg::NODE_W-1:0] r_nidx;
    logic [kdk_pkg::NODE_W-1:0] r_other;
    logic [kdk_pkg::DIST_W-1:0] r_alt;
    logic [kdk_pkg::DIST_W-1:0] r_acc;
    logic [kdk_pkg::PIDX_W-1:0] r_pidx;
    logic [kdk_pkg::DIM_W-1:0]  r_j;
    logic [kdk_pkg::HEAP_W-1:0] r_hsize;
    logic [kdk_pkg::HEAP_W-1:0] r_hi;
    logic [kdk_pkg::HEAP_W-1:0] r_cidx;
    kdk_pkg::t_hent             r_new;
    kdk_pkg::t_hent             r_x;
    kdk_pkg::t_hent             r_child;
    logic [kdk_pkg::DIST_W-1:0] r_bd [kdk_pkg::MAX_K];
    logic [kdk_pkg::PIDX_W-1:0] r_bi [kdk_pkg::MAX_K];
    logic [kdk_pkg::K_W-1:0]    r_best_cnt;
    logic [kdk_pkg::RANK_W-1:0] r_k;

    logic                       w_accept;
    kdk_pkg::t_in_item          w_item;
    logic [kdk_pkg::K_W-1:0]    w_kc;
    logic [kdk_pkg::NODE_W-1:0] w_kk;
    logic signed [15:0]         w_a;
    logic signed [15:0]         w_b;
    logic [kdk_pkg::DIST_W-1:0] w_addend;
    logic [kdk_pkg::DIST_W-1:0] w_sum;
    logic [kdk_pkg::DIST_W-1:0] w_kth;
    logic                       w_full;
    logic                       w_hwe;
    logic [kdk_pkg::HEAP_W-1:0] w_hwa;
    logic [kdk_pkg::HEAP_W-1:0] w_hra;
    kdk_pkg::t_hent             w_hwd;
    logic [kdk_pkg::HEAP_W-1:0] w_parent;
    logic [kdk_pkg::HEAP_W-1:0] w_hsz_m1;
    logic [kdk_pkg::HEAP_W:0]   w_l;
    logic [kdk_pkg::HEAP_W:0]   w_r;
    logic [kdk_pkg::MAX_K-1:0]  w_g;
    logic [kdk_pkg::DIST_W-1:0] w_ins_d [kdk_pkg::MAX_K];
    logic [kdk_pkg::PIDX_W-1:0] w_ins_i [kdk_pkg::MAX_K];

    assign w_item   = i_req.data;
    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign w_kc = (r_cfg_k == '0) ? kdk_pkg::K_W'(1) :
                  ((r_cfg_k > kdk_pkg::K_W'(kdk_pkg::MAX_K)) ? kdk_pkg::K_W'(kdk_pkg::MAX_K)
                                                               : r_cfg_k);
    assign w_kk = (kdk_pkg::NODE_W'(w_kc) > r_pts_loaded) ? r_pts_loaded
                                                           : kdk_pkg::NODE_W'(w_kc);

    assign w_a      = (r_state == S_NODE) ? r_query[r_node_rd.axis] : r_query[r_j];
    assign w_b      = (r_state == S_NODE) ? r_node_rd.bound : r_pt_rd;
    assign w_addend = (r_state == S_BT_D) ? r_alt : r_acc;

    kdk_term_unit u_term (
        .i_clk    (i_clk),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_norm   (r_cfg_norm),
        .i_addend (w_addend),
        .o_sum    (w_sum)
    );

    assign w_kth  = r_bd[kdk_pkg::RANK_W'(r_kk - kdk_pkg::K_W'(1))];
    assign w_full = (r_best_cnt == r_kk);

    assign w_parent = (r_hi - kdk_pkg::HEAP_W'(1)) >> 1;
    assign w_hsz_m1 = r_hsize - kdk_pkg::HEAP_W'(1);
    assign w_l      = {r_hi, 1'b1};
    assign w_r      = w_l + (kdk_pkg::HEAP_W + 1)'(1);

    always_comb begin
        w_hwe = 1'b0;
        w_hwa = r_hi;
        w_hwd = r_x;
        w_hra = '0;
        case (r_state)
            S_PU_CHK: begin
                if (r_hi == '0) begin
                    w_hwe = 1'b1;
                    w_hwd = r_new;
                end else begin
                    w_hra = w_parent;
                end
            end
            S_PU_CMP: begin
                w_hwe = 1'b1;
                w_hwd = (r_hrd.cost <= r_new.cost) ? r_new : r_hrd;
            end
            S_POP1: w_hra = w_hsz_m1;
            S_SD_L: begin
                if (w_l >= {1'b0, r_hsize}) begin
                    w_hwe = 1'b1;
                end else begin
                    w_hra = w_l[kdk_pkg::HEAP_W-1:0];
                end
            end
            S_SD_LW: w_hra = w_r[kdk_pkg::HEAP_W-1:0];
            S_SD_CMP: begin
                w_hwe = 1'b1;
                w_hwd = (r_child.cost >= r_x.cost) ? r_x : r_child;
            end
            default: w_hra = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < kdk_pkg::MAX_K; i++) begin
            w_g[i] = (kdk_pkg::K_W'(i) >= r_best_cnt) || (r_bd[i] > r_acc);
        end
        for (int i = 0; i < kdk_pkg::MAX_K; i++) begin
            if (!w_g[i]) begin
                w_ins_d[i] = r_bd[i];
                w_ins_i[i] = r_bi[i];
            end else if (i == 0) begin
                w_ins_d[i] = r_acc;
                w_ins_i[i] = r_pidx;
            end else if (!w_g[i-1]) begin
                w_ins_d[i] = r_acc;
                w_ins_i[i] = r_pidx;
            end else begin
                w_ins_d[i] = r_bd[i-1];
                w_ins_i[i] = r_bi[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_item.cmd == kdk_pkg::CMD_NODE) begin
            node_mem[w_item.slot] <= '{leaf: w_item.leaf_flag, axis: w_item.axis,
                                      bound: w_item.value, lc: w_item.left_child,
                                      rc: w_item.right_child};
        end
        r_node_rd <= node_mem[r_nidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_item.cmd == kdk_pkg::CMD_POINT
                && w_item.slot < kdk_pkg::NODE_W'(kdk_pkg::MAX_POINTS)) begin
            pt_mem[{w_item.slot[kdk_pkg::PIDX_W-1:0], w_item.axis}] <= w_item.value;
        end
        r_pt_rd <= pt_mem[{r_pidx, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            heap_mem[w_hwa] <= w_hwd;
        end
        r_hrd <= heap_mem[w_hra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_k      <= kdk_pkg::K_W'(1);
            r_cfg_ml     <= kdk_pkg::LEAF_W'(1);
            r_cfg_norm   <= 1'b0;
            r_pts_loaded <= '0;
            r_kk         <= '0;
            r_emax       <= kdk_pkg::LEAF_W'(1);
            r_e          <= '0;
            r_hsize      <= '0;
            r_best_cnt   <= '0;
            r_k          <= '0;
            for (int i = 0; i < kdk_pkg::DIMS; i++) begin
                r_query[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kdk_pkg::CFG_K:      r_cfg_k    <= i_cfg_data[kdk_pkg::K_W-1:0];
                    kdk_pkg::CFG_LEAVES: r_cfg_ml   <= i_cfg_data[kdk_pkg::LEAF_W-1:0];
                    kdk_pkg::CFG_NORM:   r_cfg_norm <= i_cfg_data[0];
                    default:             r_cfg_norm <= r_cfg_norm;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_item.cmd == kdk_pkg::CMD_POINT
                                && w_item.slot < kdk_pkg::NODE_W'(kdk_pkg::MAX_POINTS)
                                && w_item.slot + kdk_pkg::NODE_W'(1) > r_pts_loaded) begin
                            r_pts_loaded <= w_item.slot + kdk_pkg::NODE_W'(1);
                        end
                        if (w_item.cmd == kdk_pkg::CMD_QUERY) begin
                            r_query[w_item.axis] <= w_item.value;
                            if (w_item.last_coord) begin
                                r_kk       <= kdk_pkg::K_W'(w_kk);
                                r_emax     <= (r_cfg_ml == '0) ? kdk_pkg::LEAF_W'(1) : r_cfg_ml;
                                r_e        <= '0;
                                r_hsize    <= '0;
                                r_best_cnt <= '0;
                                if (w_kk != '0) begin
                                    r_state <= S_OUTER;
                                end
                            end
                        end
                    end
                end
                S_OUTER: begin
                    if (r_e >= r_emax) begin
                        r_k     <= '0;
                        r_state <= (r_best_cnt == '0) ? S_IDLE : S_OUT;
                    end else if (r_e != '0) begin
                        if (r_hsize == '0) begin
                            r_k     <= '0;
                            r_state <= (r_best_cnt == '0) ? S_IDLE : S_OUT;
                        end else begin
                            r_state <= S_POP0;
                        end
                    end else begin
                        r_nidx  <= '0;
                        r_alt   <= '0;
                        r_steps <= '0;
                        r_state <= S_DESC;
                    end
                end
                S_DESC: begin
                    if (r_steps >= (kdk_pkg::NODE_W + 1)'(kdk_pkg::MAX_NODES)) begin
                        r_e     <= r_e + kdk_pkg::LEAF_W'(1);
                        r_state <= S_OUTER;
                    end else begin
                        r_steps <= r_steps + (kdk_pkg::NODE_W + 1)'(1);
                        r_state <= S_NODE;
                    end
                end
                S_NODE: begin
                    if (r_node_rd.leaf) begin
                        if (r_node_rd.lc < kdk_pkg::NODE_W'(kdk_pkg::MAX_POINTS)) begin
                            r_pidx  <= r_node_rd.lc[kdk_pkg::PIDX_W-1:0];
                            r_j     <= '0;
                            r_acc   <= '0;
                            r_state <= S_C_RD;
                        end else begin
                            r_e     <= r_e + kdk_pkg::LEAF_W'(1);
                            r_state <= S_OUTER;
                        end
                    end else begin
                        if (r_query[r_node_rd.axis] <= r_node_rd.bound) begin
                            r_nidx  <= r_node_rd.lc;
                            r_other <= r_node_rd.rc;
                        end else begin
                            r_nidx  <= r_node_rd.rc;
                            r_other <= r_node_rd.lc;
                        end
                        r_state <= S_BT_W;
                    end
                end
                S_BT_W: r_state <= S_BT_D;
                S_BT_D: begin
                    if (w_full && w_sum > w_kth) begin
                        r_state <= S_DESC;
                    end else begin
                        r_new   <= '{cost: w_sum, idx: r_other};
                        r_hi    <= r_hsize;
                        r_state <= S_PU_CHK;
                    end
                end
                S_PU_CHK: begin
                    if (r_hi == '0) begin
                        if (r_hsize != kdk_pkg::HEAP_W'(kdk_pkg::HEAP_DEPTH - 1)) begin
                            r_hsize <= r_hsize + kdk_pkg::HEAP_W'(1);
                        end
                        r_state <= S_DESC;
                    end else begin
                        r_state <= S_PU_CMP;
                    end
                end
                S_PU_CMP: begin
                    if (r_hrd.cost <= r_new.cost) begin
                        if (r_hsize != kdk_pkg::HEAP_W'(kdk_pkg::HEAP_DEPTH - 1)) begin
                            r_hsize <= r_hsize + kdk_pkg::HEAP_W'(1);
                        end
                        r_state <= S_DESC;
                    end else begin
                        r_hi    <= w_parent;
                        r_state <= S_PU_CHK;
                    end
                end
                S_POP0: r_state <= S_POP1;
                S_POP1: begin
                    r_nidx  <= r_hrd.idx;
                    r_alt   <= r_hrd.cost;
                    r_hsize <= w_hsz_m1;
                    r_state <= (w_hsz_m1 == '0) ? S_POPCHK : S_POP2;
                end
                S_POP2: begin
                    r_x     <= r_hrd;
                    r_hi    <= '0;
                    r_state <= S_SD_L;
                end
                S_SD_L: begin
                    r_state <= (w_l >= {1'b0, r_hsize}) ? S_POPCHK : S_SD_LW;
                end
                S_SD_LW: begin
                    r_child <= r_hrd;
                    r_cidx  <= w_l[kdk_pkg::HEAP_W-1:0];
                    r_state <= (w_r < {1'b0, r_hsize}) ? S_SD_RW : S_SD_CMP;
                end
                S_SD_RW: begin
                    if (r_hrd.cost < r_child.cost) begin
                        r_child <= r_hrd;
                        r_cidx  <= w_r[kdk_pkg::HEAP_W-1:0];
                    end
                    r_state <= S_SD_CMP;
                end
                S_SD_CMP: begin
                    if (r_child.cost >= r_x.cost) begin
                        r_state <= S_POPCHK;
                    end else begin
                        r_hi    <= r_cidx;
                        r_state <= S_SD_L;
                    end
                end
                S_POPCHK: begin
                    if (w_full && r_alt > w_kth) begin
                        r_state <= S_OUTER;
                    end else begin
                        r_steps <= '0;
                        r_state <= S_DESC;
                    end
                end
                S_C_RD:  r_state <= S_C_MAG;
                S_C_MAG: r_state <= S_C_W;
                S_C_W:   r_state <= S_C_ACC;
                S_C_ACC: begin
                    r_acc <= w_sum;
                    if (r_j == kdk_pkg::DIM_W'(kdk_pkg::DIMS - 1)) begin
                        r_state <= S_INS;
                    end else begin
                        r_j     <= r_j + kdk_pkg::DIM_W'(1);
                        r_state <= S_C_RD;
                    end
                end
                S_INS: begin
                    for (int i = 0; i < kdk_pkg::MAX_K; i++) begin
                        r_bd[i] <= w_ins_d[i];
                        r_bi[i] <= w_ins_i[i];
                    end
                    if (r_best_cnt < r_kk) begin
                        r_best_cnt <= r_best_cnt + kdk_pkg::K_W'(1);
                    end
                    r_e     <= r_e + kdk_pkg::LEAF_W'(1);
                    r_state <= S_OUTER;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        if (o_rsp.data.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + kdk_pkg::RANK_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid            = (r_state == S_OUT);
    assign o_rsp.data.rank        = r_k;
    assign o_rsp.data.point_index = r_bi[r_k];
    assign o_rsp.data.distance    = r_bd[r_k];
    assign o_rsp.data.found_count = r_best_cnt;
    assign o_rsp.data.last        = ({1'b0, r_k} + kdk_pkg::K_W'(1)) == r_best_cnt;

    `KDK_ASSERT_IMP(a_best_within_k, 1'b1, r_best_cnt <= r_kk, "best list exceeds k")
    `KDK_ASSERT_IMP(a_leaves_within_max, 1'b1, r_e <= r_emax, "leaf count exceeds max_leaves")
    `KDK_ASSERT_IMP(a_no_in_while_out, i_req.ready, !o_rsp.valid, "ready while results pending")
    `KDK_ASSERT_NXT(a_last_ends_query, o_rsp.valid && o_rsp.ready && o_rsp.data.last,
        r_state == S_IDLE, "block not idle after last result")

endmodule

// ----- sv/kdk_term_unit.sv -----
// Shared distance unit: absolute difference, optional square, saturating add.
// Two register stages; depends on kdk_pkg.
module kdk_term_unit (
    input  logic                       i_clk,
    input  logic signed [15:0]         i_a,
    input  logic signed [15:0]         i_b,
    input  logic                       i_norm,
    input  logic [kdk_pkg::DIST_W-1:0] i_addend,
    output logic [kdk_pkg::DIST_W-1:0] o_sum
);

    logic signed [16:0] w_diff;
    logic [16:0]        w_neg;
    logic [15:0]        r_mag;
    logic [31:0]        r_term;
    logic [kdk_pkg::DIST_W:0] w_sum;

    assign w_diff = 17'(i_a) - 17'(i_b);
    assign w_neg  = 17'(0) - 17'(w_diff);

    always_ff @(posedge i_clk) begin
        r_mag  <= w_diff[16] ? w_neg[15:0] : w_diff[15:0];
        r_term <= i_norm ? {16'd0, r_mag} : r_mag * r_mag;
    end

    assign w_sum = {1'b0, i_addend} + (kdk_pkg::DIST_W + 1)'(r_term);
    assign o_sum = w_sum[kdk_pkg::DIST_W] ? kdk_pkg::DIST_MAX : w_sum[kdk_pkg::DIST_W-1:0];

endmodule

// ----- bench/kd_tree_knn_search_checker.sv -----
// Checker for the kd-tree neighbor search block: watches the request, result and
// register ports, predicts each search and compares every result item by field.
// Depends on kdk_pkg, kdk_in_if and kdk_out_if.
module kd_tree_knn_search_checker
    import kdk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    kdk_in_if                 i_req,
    kdk_out_if                i_rsp,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    t_node              node_mem [MAX_NODES];
    logic signed [15:0] point_mem [MAX_POINTS][DIMS];
    logic signed [15:0] query_coord [DIMS];
    int unsigned        points_used;
    logic [DIST_W-1:0]  branch_dist [HEAP_DEPTH];
    logic [NODE_W-1:0]  branch_node [HEAP_DEPTH];
    int unsigned        branch_count;
    logic [DIST_W-1:0]  near_dist [MAX_K+1];
    int unsigned        near_point [MAX_K+1];
    int unsigned        near_count;
    logic [K_W-1:0]     k_reg;
    logic [15:0]        leaves_reg;
    logic               norm_reg;
    t_out_item          neighbor_q [$];

    function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] coord_term(int a, int b);
        int df;
        longint unsigned m;
        df = a - b;
        m = (df < 0) ? longint'(-df) : longint'(df);
        return norm_reg ? m[DIST_W-1:0] : DIST_W'(m * m);
    endfunction

    function automatic void branch_push(logic [DIST_W-1:0] d, logic [NODE_W-1:0] idx);
        int unsigned i, p;
        logic [DIST_W-1:0] td;
        logic [NODE_W-1:0] ti;
        i = branch_count;
        branch_dist[i] = d;
        branch_node[i] = idx;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (branch_dist[p] <= d) break;
            td = branch_dist[i]; branch_dist[i] = branch_dist[p]; branch_dist[p] = td;
            ti = branch_node[i]; branch_node[i] = branch_node[p]; branch_node[p] = ti;
            i = p;
        end
        if (branch_count + 1 < HEAP_DEPTH) branch_count++;
    endfunction

    function automatic void branch_pop(output int unsigned idx, output logic [DIST_W-1:0] d);
        int unsigned i, l, r;
        logic [DIST_W-1:0] v, td;
        logic [NODE_W-1:0] ti;
        idx = branch_node[0];
        d = branch_dist[0];
        branch_count--;
        if (branch_count > 0) begin
            td = branch_dist[0]; branch_dist[0] = branch_dist[branch_count];
            branch_dist[branch_count] = td;
            ti = branch_node[0]; branch_node[0] = branch_node[branch_count];
            branch_node[branch_count] = ti;
            v = branch_dist[0];
            i = 0;
            forever begin
                l = i * 2 + 1;
                r = i * 2 + 2;
                if (l >= branch_count) break;
                if (r < branch_count && branch_dist[r] < branch_dist[l]) l = r;
                if (branch_dist[l] >= v) break;
                td = branch_dist[i]; branch_dist[i] = branch_dist[l]; branch_dist[l] = td;
                ti = branch_node[i]; branch_node[i] = branch_node[l]; branch_node[l] = ti;
                i = l;
            end
        end
    endfunction

    function automatic void add_neighbor(int unsigned p, int unsigned kk);
        logic [DIST_W-1:0] d, td;
        int unsigned ti;
        int i;
        d = '0;
        for (int j = 0; j < DIMS; j++)
            d = sat_sum(d, coord_term(int'(query_coord[j]), int'(point_mem[p][j])));
        near_dist[near_count] = d;
        near_point[near_count] = p;
        for (i = int'(near_count) - 1; i >= 0; i--) begin
            if (near_dist[i] <= d) break;
            td = near_dist[i]; near_dist[i] = near_dist[i+1]; near_dist[i+1] = td;
            ti = near_point[i]; near_point[i] = near_point[i+1]; near_point[i+1] = ti;
        end
        if (near_count < kk) near_count++;
    endfunction

    function automatic void predict_search();
        int unsigned kk, emax, e, nidx, steps, other;
        logic [DIST_W-1:0] alt_d, d;
        t_node n;
        int q;
        t_out_item r;
        kk = k_reg;
        emax = leaves_reg;
        e = 0;
        if (kk < 1) kk = 1;
        if (kk > MAX_K) kk = MAX_K;
        if (kk > points_used) kk = points_used;
        if (emax < 1) emax = 1;
        branch_count = 0;
        near_count = 0;
        if (kk == 0) return;
        while (e < emax) begin
            nidx = 0;
            steps = 0;
            alt_d = '0;
            if (e != 0) begin
                if (branch_count == 0) break;
                branch_pop(nidx, alt_d);
                if (near_count == kk && alt_d > near_dist[kk-1]) continue;
            end
            forever begin
                if (nidx >= MAX_NODES || steps >= MAX_NODES) begin
                    e++;
                    break;
                end
                steps++;
                n = node_mem[nidx];
                if (n.leaf) begin
                    if (n.lc < MAX_POINTS) add_neighbor(n.lc, kk);
                    e++;
                    break;
                end
                q = (n.axis < DIMS) ? int'(query_coord[n.axis]) : 0;
                if (q <= int'(n.bound)) begin
                    nidx = n.lc;
                    other = n.rc;
                end else begin
                    nidx = n.rc;
                    other = n.lc;
                end
                d = sat_sum(coord_term(q, int'(n.bound)), alt_d);
                if (near_count == kk && d > near_dist[kk-1]) continue;
                branch_push(d, other[NODE_W-1:0]);
            end
        end
        for (int unsigned k = 0; k < near_count; k++) begin
            r.rank = k[RANK_W-1:0];
            r.point_index = near_point[k][PIDX_W-1:0];
            r.distance = near_dist[k];
            r.found_count = near_count[K_W-1:0];
            r.last = (k + 1 == near_count);
            neighbor_q = {neighbor_q, r};
        end
    endfunction

    always @(posedge i_clk) begin
        t_in_item it;
        t_out_item want, got;
        if (!i_rst_n) begin
            for (int j = 0; j < DIMS; j++) query_coord[j] = '0;
            points_used = 0;
            branch_count = 0;
            near_count = 0;
            k_reg = 5'd1;
            leaves_reg = 16'd1;
            norm_reg = 1'b0;
            neighbor_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_K:      k_reg = i_cfg_data[K_W-1:0];
                    CFG_LEAVES: leaves_reg = i_cfg_data[15:0];
                    CFG_NORM:   norm_reg = i_cfg_data[0];
                    default:    ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (neighbor_q.size() == 0) begin
                    $error("result item with no expectation: point_index %0d", got.point_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = neighbor_q.pop_front();
                    if (got !== want) begin
                        if (got.rank !== want.rank)
                            $error("rank expected %0d actual %0d", want.rank, got.rank);
                        if (got.point_index !== want.point_index)
                            $error("point_index expected %0d actual %0d",
                                   want.point_index, got.point_index);
                        if (got.distance !== want.distance)
                            $error("distance expected %0d actual %0d",
                                   want.distance, got.distance);
                        if (got.found_count !== want.found_count)
                            $error("found_count expected %0d actual %0d",
                                   want.found_count, got.found_count);
                        if (got.last !== want.last)
                            $error("last expected %0d actual %0d", want.last, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                it = i_req.data;
                case (it.cmd)
                    CMD_NODE: begin
                        node_mem[it.slot] = '{it.leaf_flag, it.axis, it.value,
                                              it.left_child, it.right_child};
                    end
                    CMD_POINT: begin
                        if (it.slot < MAX_POINTS) begin
                            point_mem[it.slot][it.axis] = it.value;
                            if (it.slot + 1 > points_used) points_used = it.slot + 1;
                        end
                    end
                    CMD_QUERY: begin
                        query_coord[it.axis] = it.value;
                        if (it.last_coord) predict_search();
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= neighbor_q.size();
    end

endmodule

// ----- bench/kd_tree_knn_search_tb.sv -----
// Top of the kd-tree neighbor search testbench: clock, reset, register writes,
// tree loads and queries with random idling; the checker judges the results.
// Depends on kdk_pkg, kdk_in_if, kdk_out_if, kd_tree_knn_search and the checker.
module kd_tree_knn_search_tb;
    import kdk_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_idx;
    logic [CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                sent_count = 0;
    int                stall_left;
    bit                calm;

    kdk_in_if  req ();
    kdk_out_if rsp ();

    kd_tree_knn_search u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_rsp      (rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    kd_tree_knn_search_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("kd_tree_knn_search verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            rsp.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic t_in_item random_fields();
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.data <= it;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_noise();
        t_in_item it;
        it = random_fields();
        if ($urandom_range(0, 1) == 0) begin
            it.cmd = CMD_IGNORED;
        end else begin
            it.cmd = CMD_POINT;
            it.slot = 10'($urandom_range(MAX_POINTS, 1023));
        end
        send_item(it);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        while (!req.ready) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_regs(input int k, input int leaves, input int norm);
        settle();
        cfg_we <= 1'b1;
        cfg_idx <= CFG_K;
        cfg_data <= CFG_DW'(k);
        @(posedge i_clk);
        cfg_idx <= CFG_LEAVES;
        cfg_data <= CFG_DW'(leaves);
        @(posedge i_clk);
        cfg_idx <= CFG_NORM;
        cfg_data <= CFG_DW'(norm);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_points(input int npts);
        t_in_item it;
        for (int p = 0; p < npts; p++) begin
            for (int a = 0; a < DIMS; a++) begin
                it = random_fields();
                it.cmd = CMD_POINT;
                it.slot = 10'(p);
                it.axis = 4'(a);
                it.value = pick_value();
                send_item(it);
                if ($urandom_range(0, 15) == 0) send_noise();
            end
        end
    endtask

    // A complete binary tree over the loaded points: node i has children
    // 2i+1 and 2i+2, and the last npts nodes are leaves.
    task automatic load_nodes(input int npts, input int bad_odds);
        t_in_item it;
        for (int i = 0; i < 2 * npts - 1; i++) begin
            it = random_fields();
            it.cmd = CMD_NODE;
            it.slot = 10'(i);
            it.value = pick_value();
            if (i < npts - 1) begin
                it.leaf_flag = 1'b0;
                it.left_child = 10'(2 * i + 1);
                it.right_child = 10'(2 * i + 2);
            end else begin
                it.leaf_flag = 1'b1;
                if (bad_odds != 0 && $urandom_range(0, bad_odds - 1) == 0)
                    it.left_child = 10'($urandom_range(MAX_POINTS, 1023));
                else
                    it.left_child = 10'(i - (npts - 1));
            end
            send_item(it);
        end
    endtask

    task automatic run_query(input int ncoords, input bit extreme);
        t_in_item it;
        for (int c = 1; c <= ncoords; c++) begin
            it = random_fields();
            it.cmd = CMD_QUERY;
            it.value = extreme ? (c[0] ? 16'sh8000 : 16'sh7FFF) : pick_value();
            if (extreme) it.axis = 4'(c - 1);
            it.last_coord = (c == ncoords);
            send_item(it);
        end
    endtask

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        calm = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Search with no points loaded.
        run_query(1, 1'b0);
        write_regs(16, 65535, 0);
        load_points(3);
        load_nodes(3, 0);
        run_query(16, 1'b1);
        run_query(3, 1'b0);
        write_regs(0, 0, 1);
        run_query(2, 1'b0);
        write_regs(31, 65535, 1);
        run_query(1, 1'b1);
        // Root that points back at itself on both sides.
        write_regs(4, 3, 0);
        it = random_fields();
        it.cmd = CMD_NODE;
        it.slot = '0;
        it.leaf_flag = 1'b0;
        it.left_child = '0;
        it.right_child = '0;
        send_item(it);
        run_query(1, 1'b0);
        // Root leaf whose point index is out of range.
        write_regs(1, 1, 1);
        it = random_fields();
        it.cmd = CMD_NODE;
        it.slot = '0;
        it.leaf_flag = 1'b1;
        it.left_child = 10'($urandom_range(MAX_POINTS, 1023));
        send_item(it);
        run_query(1, 1'b0);

        while (sent_count < 110) begin
            write_regs($urandom_range(0, 31),
                       ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 40),
                       $urandom_range(0, 1));
            load_nodes(3, ($urandom_range(0, 2) == 0) ? 3 : 0);
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(0, 3) == 0) drain();
                run_query($urandom_range(1, 6), 1'b0);
                if ($urandom_range(0, 3) == 0) send_noise();
            end
            if (sent_count > 85) calm = 1'b1;
        end

        calm = 1'b1;
        drain();
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("kd_tree_knn_search verification clean");
        end else begin
            $display("kd_tree_knn_search verification failed");
        end
        $finish;
    end

endmodule
